// File: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache table
// Controller states, command/status bundles and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int          ENTRIES_DEF = 16;
    localparam int          CAP_W       = 5;
    localparam int          KEY_W       = 32;
    localparam int          DATA_W      = 32;
    localparam int          USE_W       = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [USE_W-1:0] USE_MAX   = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EVICT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic latch;       // capture request
        logic clr;         // restart scan
        logic scan;        // issue scan reads
        logic touch;       // bump uses and make hit entry most recent
        logic write_data;  // overwrite value of hit entry
        logic insert;      // store new entry in first free slot
        logic evict;       // drop the current victim
        logic load_out;    // load the result register
    } t_cmd;

    typedef struct packed {
        logic op;
        logic hit;
        logic cap_zero;
        logic occ_ge_cap;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl: request sequencer of the LFU cache table
// Steps each request through scan, decision, eviction and response.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ctrl import lfu_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_s_tvalid,
    output logic  o_s_tready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.op == OP_PUT && !i_sts.cap_zero && !i_sts.hit && i_sts.occ_ge_cap)
                    n_state = S_EVICT;
                else
                    n_state = S_RESP;
            end
            S_EVICT: n_state = S_SCAN;
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.latch = i_s_tvalid;
                o_cmd.clr   = i_s_tvalid;
            end
            S_SCAN: o_cmd.scan = 1'b1;
            S_DECIDE: begin
                if (i_sts.op == OP_GET) begin
                    o_cmd.touch = i_sts.hit;
                end else if (!i_sts.cap_zero) begin
                    o_cmd.touch      = i_sts.hit;
                    o_cmd.write_data = i_sts.hit;
                    o_cmd.insert     = !i_sts.hit && !i_sts.occ_ge_cap;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                o_cmd.clr   = 1'b1;
            end
            S_RESP: o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/lfu_datapath.sv
// ----------------------------------------------------------------------------
// lfu_datapath: entry storage and scan logic of the LFU cache table
// Key/value/use memories, valid bits, recency ranks, victim search.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_datapath import lfu_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  wire               i_s_tuser,
    input  wire  [63:0]       i_s_tdata,
    input  wire               i_cfg_valid,
    input  wire  [7:0]        i_cfg_data,
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    output logic              o_m_tuser,
    output logic [31:0]       o_m_tdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]  key_mem  [ENTRIES];
    logic [DATA_W-1:0] data_mem [ENTRIES];
    logic [USE_W-1:0]  uses_mem [ENTRIES];

    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_rec [ENTRIES];

    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic [DATA_W-1:0]  r_val;
    logic [CAP_W-1:0]   r_cap;

    logic [CW-1:0]      r_cnt;
    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_idx;
    logic [KEY_W-1:0]   r_rd_key;
    logic [USE_W-1:0]   r_rd_uses;
    logic [DATA_W-1:0]  r_data_rd;

    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [USE_W-1:0]   r_hit_uses;
    logic               r_have;
    logic [IW-1:0]      r_v_idx;
    logic [USE_W-1:0]   r_v_uses;
    logic [IW-1:0]      r_v_rec;
    logic               r_free_ok;
    logic [IW-1:0]      r_free_idx;
    logic [CW-1:0]      r_occ;

    logic               r_out_valid;
    logic               r_out_found;
    logic [DATA_W-1:0]  r_out_data;

    logic [IW-1:0]      rd_addr;
    logic               issue;
    logic               cv, match, better, free_here;
    logic [31:0]        cap_eff;
    logic [IW-1:0]      hit_rec;
    logic [USE_W-1:0]   uses_inc;

    assign rd_addr = r_cnt[IW-1:0];
    assign issue   = i_cmd.scan && (32'(r_cnt) < ENTRIES);

    // compare stage on last cycle's read
    assign cv        = r_rd_vld && r_valid[r_rd_idx];
    assign match     = cv && (r_rd_key == r_key) && !r_hit;
    assign better    = cv && (!r_have || (r_rd_uses < r_v_uses) ||
                       (r_rd_uses == r_v_uses && r_rec[r_rd_idx] > r_v_rec));
    assign free_here = r_rd_vld && !r_valid[r_rd_idx] && !r_free_ok;

    assign cap_eff  = (32'(r_cap) > ENTRIES) ? ENTRIES : 32'(r_cap);
    assign hit_rec  = r_rec[r_hit_idx];
    assign uses_inc = (r_hit_uses == USE_MAX) ? r_hit_uses : r_hit_uses + 1'b1;

    assign o_sts.op         = r_op;
    assign o_sts.hit        = r_hit;
    assign o_sts.cap_zero   = (r_cap == '0);
    assign o_sts.occ_ge_cap = (32'(r_occ) >= cap_eff);
    assign o_sts.scan_done  = r_rd_vld && (r_rd_idx == IW'(ENTRIES - 1));
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data[CAP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_s_tuser;
            r_key <= i_s_tdata[31:0];
            r_val <= i_s_tdata[63:32];
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_rd_key  <= key_mem[rd_addr];
        r_rd_uses <= uses_mem[rd_addr];
        r_data_rd <= data_mem[r_hit_idx];
        if (i_cmd.insert) begin
            key_mem[r_free_idx]  <= r_key;
            data_mem[r_free_idx] <= r_val;
            uses_mem[r_free_idx] <= USE_W'(1);
        end else begin
            if (i_cmd.write_data) data_mem[r_hit_idx] <= r_val;
            if (i_cmd.touch)      uses_mem[r_hit_idx] <= uses_inc;
        end
    end

    // scan sequencer and trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_have   <= 1'b0;
            r_free_ok <= 1'b0;
            r_occ    <= '0;
        end else if (i_cmd.clr) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_have   <= 1'b0;
            r_free_ok <= 1'b0;
            r_occ    <= '0;
        end else begin
            r_rd_vld <= issue;
            if (issue) r_cnt <= r_cnt + 1'b1;
            if (cv) r_occ <= r_occ + 1'b1;
            if (match) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_rd_idx;
                r_hit_uses <= r_rd_uses;
            end
            if (better) begin
                r_have   <= 1'b1;
                r_v_idx  <= r_rd_idx;
                r_v_uses <= r_rd_uses;
                r_v_rec  <= r_rec[r_rd_idx];
            end
            if (free_here) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
        if (issue) r_rd_idx <= rd_addr;
    end

    // valid bits and recency ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rec[i] <= '0;
        end else if (i_cmd.evict) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) == r_v_idx) begin
                    r_valid[i] <= 1'b0;
                    r_rec[i]   <= '0;
                end else if (r_valid[i] && r_rec[i] > r_v_rec) begin
                    r_rec[i] <= r_rec[i] - 1'b1;
                end
            end
        end else if (i_cmd.insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) == r_free_idx) begin
                    r_valid[i] <= 1'b1;
                    r_rec[i]   <= '0;
                end else if (r_valid[i]) begin
                    r_rec[i] <= r_rec[i] + 1'b1;
                end
            end
        end else if (i_cmd.touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) == r_hit_idx) begin
                    r_rec[i] <= '0;
                end else if (r_valid[i] && r_rec[i] < hit_rec) begin
                    r_rec[i] <= r_rec[i] + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_found <= (r_op == OP_GET) && r_hit;
            r_out_data  <= ((r_op == OP_GET) && r_hit) ? r_data_rd : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: rtl/lfu_cache_table_top.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_top: key-value cache with LFU replacement, LRU tie break
//
// Requests enter on the s-side stream: tuser = op (0 get, 1 put),
// tdata = {value, key}. One result per request leaves on the m-side:
// tuser = found, tdata = read_value (zero unless a get hits).
// The capacity register is written on the cfg channel (always ready).
// Write it only while no request is in flight; the block does not check.
// A request is taken when the block is idle. The sequencer then reads
// all ENTRIES slots one per cycle through the key and use memories,
// finding the key match, the free slot and the eviction victim. A put
// that misses on a full table evicts the victim and scans again before
// the result is loaded into the output register.
// The result sits in an output register; a stalled receiver holds the
// block in its response step until the previous result is taken.
// Reset empties the table and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_top import lfu_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire         i_s_tuser,   // [0] op
    input  wire  [63:0] i_s_tdata,   // [31:0] key, [63:32] value
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_data,  // [4:0] capacity
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic        o_m_tuser,   // [0] found
    output logic [31:0] o_m_tdata    // [31:0] read_value
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfu_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tuser   (o_m_tuser),
        .o_m_tdata   (o_m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("nonzero value without hit");

    a_scan_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.insert || cmd.evict || cmd.touch) |-> !o_s_tready)
        else $error("table update while idle");

endmodule

`default_nettype wire

// File: tb/tb_lfu_cache_table_top.sv
// ----------------------------------------------------------------------------
// tb_lfu_cache_table_top: self-checking bench for the LFU cache table
// Drives get and put requests with random gaps and result stalls, keeps its
// own model of the table (use counts, recency ranks, capacity) and checks
// every result in order against it. Capacity is changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none

class lfu_scoreboard;
    localparam int N = 16;
    bit          valid [N];
    bit [31:0]   keys  [N];
    bit [31:0]   data  [N];
    bit [31:0]   uses  [N];
    int          rank  [N];
    int          cap;
    bit [32:0]   pending [$];
    int          errors;

    function void clear();
        foreach (valid[i]) begin
            valid[i] = 0;
            rank[i]  = 0;
        end
        cap = 16;
        pending.delete();
        errors = 0;
    endfunction

    function void set_capacity(bit [4:0] c);
        cap = c;
    endfunction

    function int occupancy();
        int n;
        n = 0;
        foreach (valid[i]) n += valid[i];
        return n;
    endfunction

    function void bump(int s);
        foreach (valid[i])
            if (valid[i] && i != s && rank[i] < rank[s]) rank[i]++;
        rank[s] = 0;
        if (uses[s] != 32'hFFFF_FFFF) uses[s]++;
    endfunction

    function void drop_victim();
        int v;
        v = -1;
        foreach (valid[i]) begin
            if (!valid[i]) continue;
            if (v < 0 || uses[i] < uses[v] || (uses[i] == uses[v] && rank[i] > rank[v]))
                v = i;
        end
        if (v < 0) return;
        valid[v] = 0;
        foreach (valid[i])
            if (valid[i] && rank[i] > rank[v]) rank[i]--;
        rank[v] = 0;
    endfunction

    function void expect_add(bit [32:0] e);
        pending.insert(pending.size(), e);
    endfunction

    // note an accepted request and queue its result {found, read_value}
    function void note_request(bit op, bit [31:0] k, bit [31:0] val);
        int hit, lim;
        hit = -1;
        lim = (cap > N) ? N : cap;
        foreach (valid[i]) if (hit < 0 && valid[i] && keys[i] == k) hit = i;
        if (op == lfu_pkg::OP_GET) begin
            if (hit >= 0) begin
                bump(hit);
                expect_add({1'b1, data[hit]});
            end else begin
                expect_add(33'd0);
            end
            return;
        end
        expect_add(33'd0);
        if (lim == 0) return;
        if (hit >= 0) begin
            bump(hit);
            data[hit] = val;
            return;
        end
        while (occupancy() >= lim) drop_victim();
        for (int i = 0; i < N; i++) begin
            if (!valid[i]) begin
                foreach (valid[j]) if (valid[j]) rank[j]++;
                valid[i] = 1;
                keys[i]  = k;
                data[i]  = val;
                uses[i]  = 1;
                rank[i]  = 0;
                break;
            end
        end
    endfunction

    function void check_result(bit found, bit [31:0] rv);
        bit [32:0] e;
        if (pending.size() == 0) begin
            $error("unexpected result found=%0d read_value=%h", found, rv);
            errors++;
            return;
        end
        e = pending[0];
        pending.delete(0);
        if (found !== e[32]) begin
            $error("found: expected %0d, got %0d", e[32], found);
            errors++;
        end
        if (rv !== e[31:0]) begin
            $error("read_value: expected %h, got %h", e[31:0], rv);
            errors++;
        end
    endfunction
endclass

module tb_lfu_cache_table_top import lfu_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic        i_s_tuser = 0;
    logic [63:0] i_s_tdata = '0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic        o_m_tuser;
    logic [31:0] o_m_tdata;

    lfu_scoreboard sb;
    bit [31:0] key_pool [8];
    int  idle_cycles;
    bit  long_hold;
    bit  done;

    lfu_cache_table_top i_dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            sb.note_request(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser, o_m_tdata);
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles > STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_m_tready <= 0;
                repeat (200) @(negedge i_clk);
                long_hold = 0;
            end else begin
                wait_n = $urandom_range(0, 18);
                if (wait_n != 0) begin
                    i_m_tready <= 0;
                    repeat (wait_n) @(negedge i_clk);
                end
            end
            i_m_tready <= 1;
        end
    end

    task automatic send_request(bit op, bit [31:0] k, bit [31:0] val, bit gaps);
        int gap_n;
        gap_n = (gaps && $urandom_range(0, 1)) ? $urandom_range(0, 18) : 0;
        if (gap_n != 0) begin
            i_s_tvalid <= 0;
            repeat (gap_n) @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= op;
        i_s_tdata  <= {val, k};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_capacity(bit [4:0] c);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data  <= {3'b000, c};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_capacity(c);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic random_phase(int count, int pool);
        bit [31:0] k;
        for (int n = 0; n < count; n++) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, pool-1)];
            send_request(1'($urandom_range(0, 1)), k, $urandom(), (n % 64) < 40);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        idle_cycles = 0;
        long_hold = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: miss, extreme keys and values, update, hit
        send_request(OP_GET, 32'h0, 32'h0, 0);
        send_request(OP_PUT, 32'h0, 32'h8000_0000, 0);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(OP_PUT, 32'h0, 32'hFFFF_FFFF, 0);
        send_request(OP_GET, 32'h0, 32'h0, 0);
        // small capacity: eviction of the least used entry
        write_capacity(5'd2);
        send_request(OP_PUT, 32'h10, 32'h1, 0);
        send_request(OP_GET, 32'h0, 32'h0, 0);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0, 0);
        send_request(OP_GET, 32'h10, 32'h0, 0);
        send_request(OP_PUT, 32'h20, 32'h2, 0);
        send_request(OP_PUT, 32'h30, 32'h3, 0);
        send_request(OP_GET, 32'h20, 32'h0, 0);
        // capacity zero: puts ignored, gets still look up
        write_capacity(5'd0);
        send_request(OP_PUT, 32'h40, 32'h4, 0);
        send_request(OP_PUT, 32'h30, 32'h5, 0);
        send_request(OP_GET, 32'h30, 32'h0, 0);
        // above table size behaves as full size
        write_capacity(5'd31);
        for (int i = 0; i < 18; i++) send_request(OP_PUT, 32'h100 + i, i, 0);

        // random: small key pools so hits and evictions are frequent
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        write_capacity(5'd16);
        random_phase(150, 8);
        write_capacity(5'd3);   // lowered below occupancy
        random_phase(100, 8);
        write_capacity(5'd1);
        random_phase(80, 4);
        write_capacity(5'd5);
        long_hold = 1;
        random_phase(150, 8);
        write_capacity(5'd0);
        random_phase(50, 8);
        write_capacity(5'($urandom_range(1, 31)));
        random_phase(150, 8);
        write_capacity(5'd16);
        random_phase(120, 8);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

// File: lfu_cache_table_top.f
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_datapath.sv
rtl/lfu_cache_table_top.sv
tb/tb_lfu_cache_table_top.sv
